/* sv/ilgf_pkg.sv */
package ilgf_pkg;

  // Buffer capacity and the widths that follow from it
  localparam int MAX_LEN = 64;
  localparam int ADDR_W  = $clog2(MAX_LEN);
  localparam int CNT_W   = ADDR_W + 1;
  localparam int FAC_W   = ADDR_W + CNT_W;

  typedef logic [7:0] byte_t;

  // Result of the shared byte comparator
  typedef struct packed {
    logic gt;
    logic eq;
  } cmp_t;

endpackage

/* sv/ilgf_ram.sv */
module ilgf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one entry, register the read data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/ilgf_cmp.sv */
module ilgf_cmp
  import ilgf_pkg::*;
(
  input  byte_t a,
  input  byte_t b,
  output cmp_t  res
);

  // Compare two bytes as unsigned values
  assign res.gt = (a > b);
  assign res.eq = (a == b);

endmodule

/* sv/inverse_lyndon_grouped_factorizer.sv */
// Inverse-order Lyndon factorizer with prefix grouping.
// Input: a request is taken at a rising edge with start high and busy low.
// Each request carries one byte of a string; in_end_of_text marks the last.
// Up to MAX_LEN bytes are buffered; later bytes are dropped and the string's
// results then carry out_overflowed.
// After the end-marked request busy rises and the block runs Duval's scan
// (continue while earlier byte >= later byte, restart on >) with one shared
// byte comparator fed by two copies of the text RAM. Each scan step reads
// the RAM, then compares; each factor found goes into the factor list.
// Grouping then merges factors that are prefixes of the group head; each
// factor is read from the factor list, and each byte is read and compared.
// A new byte can be loaded as soon as the last one is taken. Every
// comparison waits on a registered RAM read. In a strictly rising string
// each byte is a factor of its own.
// Results: one per merged group, shown on the out_ ports for exactly one
// cycle with out_strobe high; the receiver cannot stall them. The last group
// carries out_final_group, and busy falls in the same cycle it appears.
// Reset (rst_n low, synchronous) empties the buffer and clears the flag.
module inverse_lyndon_grouped_factorizer
  import ilgf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [7:0]        in_text_byte,
  input  logic              in_end_of_text,
  output logic              out_strobe,
  output logic [ADDR_W-1:0] out_group_start,
  output logic [CNT_W-1:0]  out_group_length,
  output logic              out_final_group,
  output logic              out_overflowed
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_S_INIT, ST_S_CHK, ST_S_CMP, ST_F_EMIT,
    ST_G_RDI, ST_G_LDI, ST_G_RDJ, ST_G_LDJ, ST_P_RD, ST_P_CMP, ST_G_EMIT
  } state_t;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LEN);

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, fc_r, fc_nxt;
  logic             ovf_r, ovf_nxt;
  logic [CNT_W-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [CNT_W-1:0] gi_r, gi_nxt, gj_r, gj_nxt, t_r, t_nxt;
  logic [ADDR_W-1:0] si_r, si_nxt, sj_r, sj_nxt;
  logic [CNT_W-1:0] li_r, li_nxt, lj_r, lj_nxt, end_r, end_nxt;

  logic              ostb_r, ostb_nxt, ofin_r, ofin_nxt, oovf_r, oovf_nxt;
  logic [ADDR_W-1:0] ostart_r, ostart_nxt;
  logic [CNT_W-1:0]  olen_r, olen_nxt;

  logic              text_we;
  logic [ADDR_W-1:0] rda_addr, rdb_addr;
  byte_t             rda_data, rdb_data;
  logic              fac_we;
  logic [ADDR_W-1:0] fac_raddr;
  logic [FAC_W-1:0]  fac_wdata, fac_rdata;
  logic [ADDR_W-1:0] fac_rd_start;
  logic [CNT_W-1:0]  fac_rd_len, len_w;
  cmp_t              cmp;

  // Two copies of the text so that two bytes can be read per cycle
  ilgf_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_text_a (
    .clk(clk), .we(text_we), .waddr(cnt_r[ADDR_W-1:0]), .wdata(in_text_byte),
    .raddr(rda_addr), .rdata(rda_data)
  );

  ilgf_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_text_b (
    .clk(clk), .we(text_we), .waddr(cnt_r[ADDR_W-1:0]), .wdata(in_text_byte),
    .raddr(rdb_addr), .rdata(rdb_data)
  );

  // Factor list: start and length per entry
  ilgf_ram #(.WIDTH(FAC_W), .DEPTH(MAX_LEN)) u_factors (
    .clk(clk), .we(fac_we), .waddr(fc_r[ADDR_W-1:0]), .wdata(fac_wdata),
    .raddr(fac_raddr), .rdata(fac_rdata)
  );

  ilgf_cmp u_cmp (.a(rda_data), .b(rdb_data), .res(cmp));

  assign len_w        = j_r - k_r;
  assign fac_wdata    = {i_r[ADDR_W-1:0], len_w};
  assign fac_rd_start = fac_rdata[FAC_W-1:CNT_W];
  assign fac_rd_len   = fac_rdata[CNT_W-1:0];

  // Sequencer
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    fc_nxt     = fc_r;
    ovf_nxt    = ovf_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    k_nxt      = k_r;
    gi_nxt     = gi_r;
    gj_nxt     = gj_r;
    t_nxt      = t_r;
    si_nxt     = si_r;
    sj_nxt     = sj_r;
    li_nxt     = li_r;
    lj_nxt     = lj_r;
    end_nxt    = end_r;
    ostb_nxt   = 1'b0;
    ofin_nxt   = ofin_r;
    oovf_nxt   = oovf_r;
    ostart_nxt = ostart_r;
    olen_nxt   = olen_r;
    text_we    = 1'b0;
    fac_we     = 1'b0;
    rda_addr   = '0;
    rdb_addr   = '0;
    fac_raddr  = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          // Store the byte, or drop it and flag the overflow
          if (cnt_r < MAX_CNT) begin
            text_we = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_end_of_text) begin
            i_nxt     = '0;
            fc_nxt    = '0;
            state_nxt = ST_S_INIT;
          end
        end
      end
      ST_S_INIT: begin
        if (i_r < cnt_r) begin
          j_nxt     = i_r + 1'b1;
          k_nxt     = i_r;
          state_nxt = ST_S_CHK;
        end else begin
          gi_nxt    = '0;
          state_nxt = ST_G_RDI;
        end
      end
      ST_S_CHK: begin
        if (j_r < cnt_r) begin
          rda_addr  = k_r[ADDR_W-1:0];
          rdb_addr  = j_r[ADDR_W-1:0];
          state_nxt = ST_S_CMP;
        end else begin
          state_nxt = ST_F_EMIT;
        end
      end
      ST_S_CMP: begin
        // Continue while text[k] >= text[j], restart k on >
        if (cmp.gt || cmp.eq) begin
          k_nxt     = cmp.gt ? i_r : k_r + 1'b1;
          j_nxt     = j_r + 1'b1;
          state_nxt = ST_S_CHK;
        end else begin
          state_nxt = ST_F_EMIT;
        end
      end
      ST_F_EMIT: begin
        // Record one factor of length j-k per cycle
        if (i_r <= k_r && fc_r < MAX_CNT) begin
          fac_we = 1'b1;
          fc_nxt = fc_r + 1'b1;
          i_nxt  = i_r + len_w;
        end else begin
          state_nxt = ST_S_INIT;
        end
      end
      ST_G_RDI: begin
        fac_raddr = gi_r[ADDR_W-1:0];
        state_nxt = ST_G_LDI;
      end
      ST_G_LDI: begin
        si_nxt    = fac_rd_start;
        li_nxt    = fac_rd_len;
        end_nxt   = {1'b0, fac_rd_start} + fac_rd_len;
        gj_nxt    = gi_r + 1'b1;
        state_nxt = ST_G_RDJ;
      end
      ST_G_RDJ: begin
        if (gj_r < fc_r) begin
          fac_raddr = gj_r[ADDR_W-1:0];
          state_nxt = ST_G_LDJ;
        end else begin
          state_nxt = ST_G_EMIT;
        end
      end
      ST_G_LDJ: begin
        sj_nxt = fac_rd_start;
        lj_nxt = fac_rd_len;
        t_nxt  = '0;
        // A longer factor cannot be a prefix of the group head
        if (fac_rd_len > li_r) begin
          state_nxt = ST_G_EMIT;
        end else begin
          state_nxt = ST_P_RD;
        end
      end
      ST_P_RD: begin
        rda_addr  = si_r + t_r[ADDR_W-1:0];
        rdb_addr  = sj_r + t_r[ADDR_W-1:0];
        state_nxt = ST_P_CMP;
      end
      ST_P_CMP: begin
        if (!cmp.eq) begin
          state_nxt = ST_G_EMIT;
        end else if (t_r + 1'b1 == lj_r) begin
          // Whole factor matched: absorb it into the group
          end_nxt   = {1'b0, sj_r} + lj_r;
          gj_nxt    = gj_r + 1'b1;
          state_nxt = ST_G_RDJ;
        end else begin
          t_nxt     = t_r + 1'b1;
          state_nxt = ST_P_RD;
        end
      end
      ST_G_EMIT: begin
        ostb_nxt   = 1'b1;
        ostart_nxt = si_r;
        olen_nxt   = end_r - {1'b0, si_r};
        ofin_nxt   = (gj_r >= fc_r);
        oovf_nxt   = ovf_r;
        gi_nxt     = gj_r;
        if (gj_r >= fc_r) begin
          // Last group: empty the buffer for the next string
          cnt_nxt   = '0;
          fc_nxt    = '0;
          ovf_nxt   = 1'b0;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_G_RDI;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Hold state, pointers and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      fc_r    <= '0;
      ovf_r   <= 1'b0;
      i_r     <= '0;
      j_r     <= '0;
      k_r     <= '0;
      ostb_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      fc_r    <= fc_nxt;
      ovf_r   <= ovf_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      k_r     <= k_nxt;
      ostb_r  <= ostb_nxt;
    end
    gi_r     <= gi_nxt;
    gj_r     <= gj_nxt;
    t_r      <= t_nxt;
    si_r     <= si_nxt;
    sj_r     <= sj_nxt;
    li_r     <= li_nxt;
    lj_r     <= lj_nxt;
    end_r    <= end_nxt;
    ofin_r   <= ofin_nxt;
    oovf_r   <= oovf_nxt;
    ostart_r <= ostart_nxt;
    olen_r   <= olen_nxt;
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_strobe       = ostb_r;
  assign out_group_start  = ostart_r;
  assign out_group_length = olen_r;
  assign out_final_group  = ofin_r;
  assign out_overflowed   = oovf_r;

`ifndef NO_ASSERTIONS
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_group_length != '0)
    else $error("empty group emitted");

  a_group_fits: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ({1'b0, out_group_start} + out_group_length) <= MAX_CNT)
    else $error("group runs past the buffer");

  a_more_groups_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_final_group) |-> busy)
    else $error("block went idle before the last group");

  a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_final_group) |-> !busy)
    else $error("block still busy after the last group");
`endif

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import ilgf_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 238;
  localparam int TAIL_CYCLES = 40;

  // One byte request plus a flag that holds it back until all groups are out
  typedef struct {
    byte_t text_byte;
    logic  end_mark;
    bit    drain_first;
  } text_req_t;

  // One merged group as the block should report it
  typedef struct {
    logic [ADDR_W-1:0] start;
    logic [CNT_W-1:0]  length;
    logic              last;
    logic              ovf;
  } group_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [7:0]        in_text_byte;
  logic              in_end_of_text;
  logic              out_strobe;
  logic [ADDR_W-1:0] out_group_start;
  logic [CNT_W-1:0]  out_group_length;
  logic              out_final_group;
  logic              out_overflowed;

  inverse_lyndon_grouped_factorizer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_text_byte     (in_text_byte),
    .in_end_of_text   (in_end_of_text),
    .out_strobe       (out_strobe),
    .out_group_start  (out_group_start),
    .out_group_length (out_group_length),
    .out_final_group  (out_final_group),
    .out_overflowed   (out_overflowed)
  );

  // Predictor state: the string collected so far and its factors
  byte_t text_buf [MAX_LEN];
  int    text_len;
  bit    text_ovf;
  int    fac_start [MAX_LEN];
  int    fac_len [MAX_LEN];
  int    fac_n;

  text_req_t stim_q[$];
  text_req_t cur_req;
  group_t    pending_groups[$];

  int total_items;
  int items_accepted;
  int groups_predicted;
  int groups_seen;
  int burst_left;
  int gap_left;
  int error_count;
  int cycle_count;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_text_byte   = '0;
    in_end_of_text = 1'b0;
    text_len         = 0;
    text_ovf         = 1'b0;
    fac_n            = 0;
    items_accepted   = 0;
    groups_predicted = 0;
    groups_seen      = 0;
    burst_left       = 8;
    gap_left         = 0;
    error_count      = 0;
    cycle_count      = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
  end

  task automatic report_mismatch(input string msg);
    $display("tb_top: mismatch at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // Take one accepted byte; on the end mark factorize and queue the groups
  task automatic absorb_byte(input text_req_t req);
    int     i, j, k, l, n, g, t;
    bit     same;
    group_t grp;
    if (text_len < MAX_LEN) begin
      text_buf[text_len] = req.text_byte;
      text_len++;
    end else begin
      text_ovf = 1'b1;
    end
    if (req.end_mark) begin
      // Duval scan: continue while earlier >= later, restart on >
      n = text_len;
      i = 0;
      fac_n = 0;
      while (i < n) begin
        j = i + 1;
        k = i;
        while (j < n && text_buf[k] >= text_buf[j]) begin
          if (text_buf[k] > text_buf[j])
            k = i;
          else
            k++;
          j++;
        end
        l = j - k;
        while (i <= k && fac_n < MAX_LEN) begin
          fac_start[fac_n] = i;
          fac_len[fac_n] = l;
          fac_n++;
          i += l;
        end
      end
      // Merge each head with the following factors that are its prefixes
      g = 0;
      while (g < fac_n) begin
        j = g + 1;
        same = 1'b1;
        while (j < fac_n && same) begin
          same = (fac_len[j] <= fac_len[g]);
          for (t = 0; same && t < fac_len[j]; t++) begin
            if (text_buf[(fac_start[j] + t) % MAX_LEN] !=
                text_buf[(fac_start[g] + t) % MAX_LEN])
              same = 1'b0;
          end
          if (same)
            j++;
        end
        grp.start  = ADDR_W'(fac_start[g]);
        grp.length = CNT_W'(fac_start[j-1] + fac_len[j-1] - fac_start[g]);
        grp.last   = (j >= fac_n);
        grp.ovf    = text_ovf;
        pending_groups.push_back(grp);
        groups_predicted++;
        g = j;
      end
      text_len = 0;
      fac_n = 0;
      text_ovf = 1'b0;
    end
  endtask

  task automatic add_req(input byte_t b, input logic e, input bit d);
    text_req_t r;
    r.text_byte   = b;
    r.end_mark    = e;
    r.drain_first = d;
    stim_q.push_back(r);
  endtask

  // Queue one string: random bytes, a narrow alphabet, or a repeated pattern
  task automatic add_random_string(input int len, input bit drain);
    int    mode, span, p, idx;
    byte_t base;
    byte_t pat [4];
    byte_t b;
    mode = $urandom_range(0, 3);
    base = byte_t'($urandom);
    span = $urandom_range(1, 3);
    p = $urandom_range(1, 3);
    for (idx = 0; idx < 4; idx++)
      pat[idx] = byte_t'(base + $urandom_range(0, 2));
    for (idx = 0; idx < len; idx++) begin
      case (mode)
        0: b = byte_t'($urandom);
        1: b = byte_t'(base + $urandom_range(0, span - 1));
        default: begin
          b = pat[idx % p];
          if (idx == len - 1 && $urandom_range(0, 2) == 0)
            b = byte_t'(base + $urandom_range(0, 2));
        end
      endcase
      add_req(b, idx == len - 1, drain && idx == 0);
    end
  endtask

  // Build the stimulus, then wait for everything to drain
  initial begin : stimulus
    int rand_items;
    int strings;
    int len;
    // Single-byte strings at both byte extremes
    add_req(8'h00, 1'b1, 1'b1);
    add_req(8'hFF, 1'b1, 1'b0);
    // Falling pair forms one factor, rising pair two
    add_req(8'hFF, 1'b0, 1'b0);
    add_req(8'h00, 1'b1, 1'b0);
    add_req(8'h00, 1'b0, 1'b0);
    add_req(8'hFF, 1'b1, 1'b0);
    // Equal run: factors of one byte merged into one group
    add_req(8'h55, 1'b0, 1'b0);
    add_req(8'h55, 1'b0, 1'b0);
    add_req(8'h55, 1'b1, 1'b0);
    // Alternating bit patterns
    add_req(8'hA5, 1'b0, 1'b0);
    add_req(8'h5A, 1'b0, 1'b0);
    add_req(8'hA5, 1'b0, 1'b0);
    add_req(8'h5A, 1'b0, 1'b0);
    add_req(8'hA5, 1'b1, 1'b0);
    add_req(8'h01, 1'b0, 1'b0);
    add_req(8'h02, 1'b0, 1'b0);
    add_req(8'h01, 1'b0, 1'b0);
    add_req(8'h02, 1'b0, 1'b0);
    add_req(8'h01, 1'b1, 1'b0);
    add_req(8'h80, 1'b0, 1'b0);
    add_req(8'h7F, 1'b0, 1'b0);
    add_req(8'h80, 1'b1, 1'b1);

    rand_items = 0;
    strings = 0;
    while (rand_items < RANDOM_ITEMS || strings < 9) begin
      // Exactly full, then overflow with the end-marked byte dropped
      if (strings == 2)
        len = MAX_LEN;
      else if (strings == 8)
        len = MAX_LEN + 3;
      else if ($urandom_range(0, 4) == 0)
        len = $urandom_range(13, 24);
      else
        len = $urandom_range(1, 10);
      add_random_string(len, $urandom_range(0, 7) == 0);
      rand_items += len;
      strings++;
    end
    total_items = stim_q.size();

    wait (items_accepted == total_items);
    while (pending_groups.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_groups.size() == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

  // Driver: present requests in bursts, hold while busy, drain on demand
  always @(posedge clk) begin
    if (!rst_n) begin
      start          <= 1'b0;
      in_text_byte   <= '0;
      in_end_of_text <= 1'b0;
    end else begin
      if (start && !busy) begin
        absorb_byte(cur_req);
        items_accepted++;
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (stim_q.size() == 0 ||
                     (stim_q[0].drain_first && groups_predicted != groups_seen)) begin
          start <= 1'b0;
        end else begin
          cur_req = stim_q.pop_front();
          start          <= 1'b1;
          in_text_byte   <= cur_req.text_byte;
          in_end_of_text <= cur_req.end_mark;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end
        end
      end
    end
  end

  // Monitor: compare each strobed group with the oldest expectation
  always @(posedge clk) begin : watch_groups
    group_t want;
    if (rst_n) begin
      if (out_strobe === 1'bx) begin
        report_mismatch("out_strobe unknown");
      end else if (out_strobe) begin
        if (pending_groups.size() == 0) begin
          report_mismatch($sformatf("unexpected group start=%0d len=%0d",
                                    out_group_start, out_group_length));
        end else begin
          want = pending_groups.pop_front();
          groups_seen <= groups_seen + 1;
          if (out_group_start !== want.start)
            report_mismatch($sformatf("group_start got %0d want %0d",
                                      out_group_start, want.start));
          if (out_group_length !== want.length)
            report_mismatch($sformatf("group_length got %0d want %0d",
                                      out_group_length, want.length));
          if (out_final_group !== want.last)
            report_mismatch($sformatf("final_group got %b want %b",
                                      out_final_group, want.last));
          if (out_overflowed !== want.ovf)
            report_mismatch($sformatf("overflowed got %b want %b",
                                      out_overflowed, want.ovf));
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

endmodule

/* filelist.f */
sv/ilgf_pkg.sv
sv/ilgf_ram.sv
sv/ilgf_cmp.sv
sv/inverse_lyndon_grouped_factorizer.sv
tb/tb_top.sv
